// ===== hdl/ocmm_pkg.sv =====
package ocmm_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_Y     = 8'h79;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_L     = 8'h6C;

	localparam int unsigned WIN_DEPTH = 8;

	localparam logic [3:0] CNT_FADER  = 4'd11;
	localparam logic [3:0] CNT_XY     = 4'd14;
	localparam logic [3:0] CNT_SWITCH = 4'd10;

	localparam logic [3:0] CTRL_FADER1  = 4'd0;
	localparam logic [3:0] CTRL_XY1     = 4'd4;
	localparam logic [3:0] CTRL_XY2     = 4'd5;
	localparam logic [3:0] CTRL_PUSH1   = 4'd6;
	localparam logic [3:0] CTRL_TOGGLE1 = 4'd10;
	localparam logic [3:0] CTRL_TOGGLE4 = 4'd13;
	localparam logic [3:0] CTRL_NONE    = 4'd14;

	localparam logic [31:0] FLT_MAG_MASK = 32'h7FFF_FFFF;
	localparam logic [30:0] FLT_INF_MAG  = 31'h7F80_0000;
	localparam logic [30:0] FLT_ONE_MAG  = 31'h3F80_0000;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_NAME    = 2'd1,
		PH_COUNT   = 2'd2,
		PH_SPARE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_PAGE       = 3'd0,
		EV_RESTART    = 3'd1,
		EV_UPDATE     = 3'd2,
		EV_FIRST_BAD  = 3'd3,
		EV_SECOND_BAD = 3'd4
	} event_t;

	// NaN, +0 and -0 pass; otherwise 0 <= x <= 1
	function automatic logic in_unit_range(input logic [31:0] bits);
		logic [30:0] mag;
		logic        ok;
		mag = bits[30:0];
		if (mag > FLT_INF_MAG)
			ok = 1'b1;
		else if (mag == '0)
			ok = 1'b1;
		else if (bits[31])
			ok = 1'b0;
		else
			ok = (mag <= FLT_ONE_MAG);
		return ok;
	endfunction

	// digit '1' .. '4' selects base+offset, else keep old
	function automatic logic [3:0] pick_digit(input logic [7:0] d, input logic [3:0] base,
			input logic [3:0] old);
		logic [7:0] off;
		off = d - CH_ONE;
		if (d >= CH_ONE && off < 8'd4)
			return base + off[3:0];
		return old;
	endfunction

endpackage

// ===== hdl/osc_control_message_matcher.sv =====
// Channel  | Group    | tdata (low bit up)                             | tuser
// ---------+----------+------------------------------------------------+-------------
// input    | s_axis_* | rx_byte[7:0]                                   | bytes_lost
// result   | m_axis_* | page[7:0] control[11:8] value_last[43:12]      | event_res
//          |          | value_prior[75:44] switch_level[76], pad zeros |
//
// One word per cycle unless stalled: the byte window, parse state and result register all
// update on the accepting edge; a result is visible the cycle after its word.
// Reset clears window, parse state and the result valid flag.
// The input is stalled only while a result is held and the output side is not ready.
module osc_control_message_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic        s_axis_tuser,   // bytes_lost
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // page, control, value_last, value_prior, switch_level
	output logic [2:0]  m_axis_tuser    // event_res
);

	logic [7:0]          win_q [ocmm_pkg::WIN_DEPTH];
	ocmm_pkg::phase_t    phase_q, phase_next;
	logic                hunt_q, hunt_next;
	logic [3:0]          cnt_q, cnt_next;
	logic                two_q, two_next;
	logic [3:0]          sel_q, sel_next;

	logic                out_valid_q;
	ocmm_pkg::event_t    ev_q, ev_next;
	logic [7:0]          page_q, page_next;
	logic [3:0]          ctrl_q, ctrl_next;
	logic [31:0]         vlast_q, vlast_next;
	logic [31:0]         vprior_q, vprior_next;
	logic                level_q, level_next;
	logic                res_next;

	logic                accept;
	logic                hunt_eff;
	ocmm_pkg::phase_t    phase_eff;
	logic [7:0]          b;
	logic                is_header;
	logic                m_fader, m_xy, m_push, m_toggle;
	logic [3:0]          cnt_dec;
	logic [31:0]         v1, v2;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;

	assign hunt_eff  = hunt_q || s_axis_tuser;
	assign phase_eff = s_axis_tuser ? ocmm_pkg::PH_HEADER : phase_q;

	// window after the shift: entry 0 is b, entry i is win_q[i-1]
	assign is_header = (b == ocmm_pkg::CH_SLASH) && (win_q[1] == ocmm_pkg::CH_SLASH);
	assign m_fader   = (win_q[2] == ocmm_pkg::CH_D) && (win_q[1] == ocmm_pkg::CH_E)
		&& (win_q[0] == ocmm_pkg::CH_R);
	assign m_xy      = (win_q[1] == ocmm_pkg::CH_X) && (win_q[0] == ocmm_pkg::CH_Y);
	assign m_push    = (win_q[2] == ocmm_pkg::CH_U) && (win_q[1] == ocmm_pkg::CH_S)
		&& (win_q[0] == ocmm_pkg::CH_H);
	assign m_toggle  = (win_q[2] == ocmm_pkg::CH_G) && (win_q[1] == ocmm_pkg::CH_L)
		&& (win_q[0] == ocmm_pkg::CH_E);
	assign cnt_dec   = cnt_q - 4'd1;
	assign v1        = {win_q[2], win_q[1], win_q[0], b};
	assign v2        = two_q ? {win_q[6], win_q[5], win_q[4], win_q[3]} : '0;

	// next parse state
	always_comb begin
		phase_next = phase_eff;
		hunt_next  = hunt_eff;
		cnt_next   = cnt_q;
		two_next   = two_q;
		sel_next   = sel_q;
		if (hunt_eff) begin
			if (b == ocmm_pkg::CH_SLASH)
				hunt_next = 1'b0;
		end else if (is_header) begin
			phase_next = ocmm_pkg::PH_NAME;
		end else begin
			unique case (phase_eff)
				ocmm_pkg::PH_NAME: begin
					if (m_fader) begin
						phase_next = ocmm_pkg::PH_COUNT;
						cnt_next   = ocmm_pkg::CNT_FADER;
						two_next   = 1'b0;
						sel_next   = ocmm_pkg::pick_digit(b, ocmm_pkg::CTRL_FADER1, sel_q);
					end else if (m_xy) begin
						phase_next = ocmm_pkg::PH_COUNT;
						cnt_next   = ocmm_pkg::CNT_XY;
						two_next   = 1'b1;
						sel_next   = (b == ocmm_pkg::CH_TWO) ? ocmm_pkg::CTRL_XY2
							: ocmm_pkg::CTRL_XY1;
					end else if (m_push) begin
						phase_next = ocmm_pkg::PH_COUNT;
						cnt_next   = ocmm_pkg::CNT_SWITCH;
						two_next   = 1'b0;
						sel_next   = ocmm_pkg::pick_digit(b, ocmm_pkg::CTRL_PUSH1, sel_q);
					end else if (m_toggle) begin
						phase_next = ocmm_pkg::PH_COUNT;
						cnt_next   = ocmm_pkg::CNT_SWITCH;
						two_next   = 1'b0;
						sel_next   = ocmm_pkg::pick_digit(b, ocmm_pkg::CTRL_TOGGLE1, sel_q);
					end
				end
				ocmm_pkg::PH_COUNT: begin
					cnt_next = cnt_dec;
					if (cnt_dec == '0)
						phase_next = ocmm_pkg::PH_HEADER;
				end
				default: ;
			endcase
		end
	end

	// result for this word
	always_comb begin
		res_next    = 1'b0;
		ev_next     = ocmm_pkg::EV_UPDATE;
		page_next   = '0;
		ctrl_next   = ocmm_pkg::CTRL_NONE;
		vlast_next  = '0;
		vprior_next = '0;
		level_next  = 1'b0;
		if (!hunt_eff) begin
			if (is_header) begin
				res_next = 1'b1;
				if (phase_eff == ocmm_pkg::PH_HEADER) begin
					ev_next   = ocmm_pkg::EV_PAGE;
					page_next = win_q[0] - ocmm_pkg::CH_ZERO;
				end else begin
					ev_next = ocmm_pkg::EV_RESTART;
				end
			end else if (phase_eff == ocmm_pkg::PH_COUNT && cnt_dec == '0) begin
				res_next    = 1'b1;
				ctrl_next   = sel_q;
				vlast_next  = v1;
				vprior_next = v2;
				if (!ocmm_pkg::in_unit_range(v1)) begin
					ev_next = ocmm_pkg::EV_FIRST_BAD;
				end else if (two_q && !ocmm_pkg::in_unit_range(v2)) begin
					ev_next = ocmm_pkg::EV_SECOND_BAD;
				end else begin
					ev_next = ocmm_pkg::EV_UPDATE;
					if (sel_q >= ocmm_pkg::CTRL_PUSH1 && sel_q <= ocmm_pkg::CTRL_TOGGLE4)
						level_next = |(v1 & ocmm_pkg::FLT_MAG_MASK);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ocmm_pkg::WIN_DEPTH; i++)
				win_q[i] <= '0;
			phase_q <= ocmm_pkg::PH_HEADER;
			hunt_q  <= 1'b0;
			cnt_q   <= '0;
			two_q   <= 1'b0;
			sel_q   <= ocmm_pkg::CTRL_NONE;
		end else if (accept) begin
			phase_q <= phase_next;
			hunt_q  <= hunt_next;
			cnt_q   <= cnt_next;
			two_q   <= two_next;
			sel_q   <= sel_next;
			if (hunt_eff) begin
				// a slash ends the hunt and lands in the newest slot without a shift
				if (b == ocmm_pkg::CH_SLASH)
					win_q[0] <= b;
			end else begin
				for (int i = ocmm_pkg::WIN_DEPTH - 1; i > 0; i--)
					win_q[i] <= win_q[i-1];
				win_q[0] <= b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_next;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_next) begin
			ev_q     <= ev_next;
			page_q   <= page_next;
			ctrl_q   <= ctrl_next;
			vlast_q  <= vlast_next;
			vprior_q <= vprior_next;
			level_q  <= level_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = ev_q;
	assign m_axis_tdata  = {3'b000, level_q, vprior_q, vlast_q, ctrl_q, page_q};

endmodule

// ===== sim/osc_control_message_matcher_tb.sv =====
`timescale 1ns / 100ps

module osc_control_message_matcher_tb;

	import ocmm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;

	localparam int MSG_FADER  = 0;
	localparam int MSG_XY     = 1;
	localparam int MSG_PUSH   = 2;
	localparam int MSG_TOGGLE = 3;

	typedef struct packed {
		logic [2:0]  code;
		logic [7:0]  page;
		logic [3:0]  control;
		logic [31:0] value_last;
		logic [31:0] value_prior;
		logic        switch_level;
	} osc_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte
	logic        s_axis_tuser = 1'b0;    // bytes_lost
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;           // page, control, value_last, value_prior, switch_level
	logic [2:0]  m_axis_tuser;           // event_res

	// parser state mirrored on the testbench side
	logic [7:0]  win_bytes [8];
	phase_t      parse_phase;
	logic        hunting_slash;
	logic [3:0]  count_left;
	logic        pair_values;
	logic [3:0]  control_sel;

	osc_event_t  expected_events[$];
	logic [7:0]  msg_buf[$];
	int          failures = 0;
	int          bytes_sent = 0;
	bit          tx_gap_en = 1'b1;
	bit          rx_stall_en = 1'b1;
	int          rx_hold_cycles = 0;

	osc_control_message_matcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	task automatic note_failure(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		failures++;
	endtask

	// NaN, +0 and -0 count as inside [0, 1]
	function automatic bit unit_interval(input logic [31:0] f);
		if (f[30:23] == 8'hFF && f[22:0] != '0)
			return 1'b1;
		if (f[30:0] == '0)
			return 1'b1;
		return !f[31] && (f[30:0] <= FLT_ONE_MAG);
	endfunction

	function automatic void arm_value(input logic [3:0] count, input logic pair,
			input logic [3:0] base);
		parse_phase = PH_COUNT;
		count_left = count;
		pair_values = pair;
		// digits '1'..'4' pick a control, anything else keeps the old one
		if (win_bytes[0] >= CH_ONE && win_bytes[0] <= CH_ONE + 8'd3)
			control_sel = base + win_bytes[0][3:0] - 4'd1;
	endfunction

	function automatic bit match_rx_byte(input logic [7:0] b, input logic lost,
			output osc_event_t res);
		logic [31:0] newest;
		logic [31:0] older;
		int i;
		res = '0;
		res.control = CTRL_NONE;
		if (lost) begin
			parse_phase = PH_HEADER;
			hunting_slash = 1'b1;
		end
		if (hunting_slash) begin
			// a slash lands in the newest entry without a shift
			if (b == CH_SLASH) begin
				win_bytes[0] = b;
				hunting_slash = 1'b0;
			end
			return 1'b0;
		end
		for (i = 7; i > 0; i--)
			win_bytes[i] = win_bytes[i - 1];
		win_bytes[0] = b;

		if (win_bytes[0] == CH_SLASH && win_bytes[2] == CH_SLASH) begin
			if (parse_phase == PH_HEADER) begin
				res.code = EV_PAGE;
				res.page = win_bytes[1] - CH_ZERO;
			end else
				res.code = EV_RESTART;
			parse_phase = PH_NAME;
			return 1'b1;
		end

		case (parse_phase)
		PH_NAME: begin
			if (win_bytes[3] == CH_D && win_bytes[2] == CH_E && win_bytes[1] == CH_R)
				arm_value(CNT_FADER, 1'b0, CTRL_FADER1);
			else if (win_bytes[2] == CH_X && win_bytes[1] == CH_Y) begin
				parse_phase = PH_COUNT;
				count_left = CNT_XY;
				pair_values = 1'b1;
				control_sel = (win_bytes[0] == CH_TWO) ? CTRL_XY2 : CTRL_XY1;
			end else if (win_bytes[3] == CH_U && win_bytes[2] == CH_S && win_bytes[1] == CH_H)
				arm_value(CNT_SWITCH, 1'b0, CTRL_PUSH1);
			else if (win_bytes[3] == CH_G && win_bytes[2] == CH_L && win_bytes[1] == CH_E)
				arm_value(CNT_SWITCH, 1'b0, CTRL_TOGGLE1);
			return 1'b0;
		end
		PH_COUNT: begin
			count_left = count_left - 4'd1;
			if (count_left != 4'd0)
				return 1'b0;
			parse_phase = PH_HEADER;
			newest = {win_bytes[3], win_bytes[2], win_bytes[1], win_bytes[0]};
			older = pair_values ? {win_bytes[7], win_bytes[6], win_bytes[5], win_bytes[4]} : '0;
			res.control = control_sel;
			res.value_last = newest;
			res.value_prior = older;
			if (!unit_interval(newest))
				res.code = EV_FIRST_BAD;
			else if (pair_values && !unit_interval(older))
				res.code = EV_SECOND_BAD;
			else begin
				res.code = EV_UPDATE;
				if (control_sel >= CTRL_PUSH1 && control_sel <= CTRL_TOGGLE4)
					res.switch_level = (newest[30:0] != '0);
			end
			return 1'b1;
		end
		default:
			return 1'b0;
		endcase
	endfunction

	task automatic send_rx_byte(input logic [7:0] b, input logic lost);
		osc_event_t res;
		if (tx_gap_en && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= lost;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (match_rx_byte(b, lost, res))
			expected_events.push_back(res);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_rx_byte(s[i], 1'b0);
	endtask

	// drop valid and hold until every expected result has come out
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_float_bits();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 11))
		0: r = 32'h0000_0000;
		1: r = 32'h8000_0000;
		2: r = {1'b0, FLT_ONE_MAG};
		3: r = {1'b0, FLT_ONE_MAG} + 32'd1;
		4: r = {1'b0, FLT_INF_MAG};
		5: r[30:23] = 8'hFF;
		6: r[31] = 1'b1;
		7, 8: r = r % ({1'b0, FLT_ONE_MAG} + 32'd1);
		9: r = {9'h000, r[22:0]};
		default: ;
		endcase
		return r;
	endfunction

	// header, control name, padding, then big-endian value(s); y goes before x
	task automatic build_osc_message(input int kind, input logic [7:0] digit,
			input logic [31:0] val_x, input logic [31:0] val_y, input bit noisy);
		string      name_text;
		logic [3:0] count;
		bit         pair;
		logic [7:0] page_byte;
		logic [7:0] fill_byte;
		logic [63:0] payload;
		int         i;
		int         n_val;
		pair = 1'b0;
		case (kind)
		MSG_FADER: begin
			name_text = "fader";
			count = CNT_FADER;
		end
		MSG_XY: begin
			name_text = "xy";
			count = CNT_XY;
			pair = 1'b1;
		end
		MSG_PUSH: begin
			name_text = "push";
			count = CNT_SWITCH;
		end
		default: begin
			name_text = "toggle";
			count = CNT_SWITCH;
		end
		endcase
		page_byte = CH_ZERO + 8'($urandom_range(0, 9));
		if (noisy && $urandom_range(0, 3) == 0)
			page_byte = 8'($urandom);
		msg_buf.delete();
		msg_buf.push_back(CH_SLASH);
		msg_buf.push_back(page_byte);
		msg_buf.push_back(CH_SLASH);
		for (i = 0; i < name_text.len(); i++)
			msg_buf.push_back(name_text[i]);
		msg_buf.push_back(digit);
		n_val = pair ? 8 : 4;
		for (i = 0; i < count - n_val; i++) begin
			fill_byte = 8'h00;
			if (noisy && $urandom_range(0, 3) == 0)
				fill_byte = 8'($urandom);
			msg_buf.push_back(fill_byte);
		end
		payload = pair ? {val_y, val_x} : {val_x, 32'h0};
		for (i = 0; i < n_val; i++)
			msg_buf.push_back(payload[63 - 8 * i -: 8]);
	endtask

	task automatic send_osc_message(input int kind, input logic [7:0] digit,
			input logic [31:0] val_x, input logic [31:0] val_y);
		int i;
		build_osc_message(kind, digit, val_x, val_y, 1'b0);
		for (i = 0; i < msg_buf.size(); i++)
			send_rx_byte(msg_buf[i], 1'b0);
	endtask

	task automatic test_page_headers();
		send_text("/0/");
		send_text("5/");
		// lost bytes: hunt for a slash, everything else is thrown away
		send_rx_byte(8'hA5, 1'b1);
		send_rx_byte(8'h5A, 1'b0);
		send_rx_byte(CH_SLASH, 1'b0);
		send_text("7/");
		send_rx_byte(CH_SLASH, 1'b1);
		send_rx_byte(8'hFF, 1'b0);
		send_rx_byte(CH_SLASH, 1'b0);
		send_rx_byte(8'h00, 1'b1);
		send_rx_byte(CH_SLASH, 1'b0);
		send_rx_byte(8'h00, 1'b0);
		send_rx_byte(CH_SLASH, 1'b0);
	endtask

	task automatic test_control_updates();
		// fader name with a bad digit before any control was picked: update reports none
		send_text("der0");
		repeat (CNT_FADER - 4) send_rx_byte(8'h00, 1'b0);
		send_rx_byte(8'h3F, 1'b0);
		send_rx_byte(8'h80, 1'b0);
		send_rx_byte(8'h00, 1'b0);
		send_rx_byte(8'h00, 1'b0);
		send_osc_message(MSG_FADER, "4", 32'h3F80_0001, 32'h0);
		send_osc_message(MSG_XY, "2", 32'h3F00_0000, 32'h7F80_0000);
		send_osc_message(MSG_XY, "9", 32'hBF80_0000, 32'h3E80_0000);
		send_osc_message(MSG_PUSH, "1", 32'h8000_0000, 32'h0);
		send_osc_message(MSG_TOGGLE, "4", 32'hFFC0_0000, 32'h0);
		send_osc_message(MSG_PUSH, "5", 32'h0000_0001, 32'h0);
		send_osc_message(MSG_TOGGLE, "1", 32'h0000_0000, 32'h0);
		send_osc_message(MSG_XY, "1", 32'h0000_0000, 32'h3F80_0000);
		send_osc_message(MSG_FADER, "1", 32'h7F80_0000, 32'h0);
	endtask

	task automatic test_output_backpressure();
		int i;
		wait_for_results();
		rx_hold_cycles = HOLD_OFF_CYCLES;
		// every further slash restarts the header, so results pile up
		send_text("/3/");
		for (i = 0; i < 24; i++)
			send_text("1/");
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int target, input bit pauses);
		int         pick;
		int         cut;
		int         lost_at;
		int         i;
		logic [7:0] digit;
		logic [7:0] noise_byte;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 19);
			if (pick == 19) begin
				repeat ($urandom_range(1, 8)) begin
					noise_byte = 8'($urandom);
					send_rx_byte(noise_byte, $urandom_range(0, 5) == 0);
				end
			end else if (pick == 18 && pauses)
				wait_for_results();
			else begin
				digit = CH_ZERO + 8'($urandom_range(0, 5));
				if ($urandom_range(0, 15) == 0)
					digit = 8'($urandom);
				build_osc_message($urandom_range(0, 3), digit, random_float_bits(),
					random_float_bits(), $urandom_range(0, 4) == 0);
				cut = msg_buf.size();
				lost_at = -1;
				if (pick >= 16)
					cut = $urandom_range(1, cut - 1);
				else if (pick == 15)
					lost_at = $urandom_range(0, cut - 1);
				for (i = 0; i < cut; i++)
					send_rx_byte(msg_buf[i], i == lost_at);
			end
		end
	endtask

	task automatic test_steady_stream(input int target);
		tx_gap_en = 1'b0;
		rx_stall_en = 1'b0;
		test_random_traffic(target, 1'b0);
	endtask

	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (rx_hold_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else
				m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		osc_event_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_events.size() == 0)
				note_failure($sformatf("unexpected result word, event %0d", m_axis_tuser));
			else begin
				want = expected_events.pop_front();
				if (m_axis_tuser !== want.code)
					note_failure($sformatf("event_res %0d, want %0d", m_axis_tuser, want.code));
				if (m_axis_tdata[7:0] !== want.page)
					note_failure($sformatf("page %0d, want %0d", m_axis_tdata[7:0], want.page));
				if (m_axis_tdata[11:8] !== want.control)
					note_failure($sformatf("control %0d, want %0d",
						m_axis_tdata[11:8], want.control));
				if (m_axis_tdata[43:12] !== want.value_last)
					note_failure($sformatf("value_last %h, want %h",
						m_axis_tdata[43:12], want.value_last));
				if (m_axis_tdata[75:44] !== want.value_prior)
					note_failure($sformatf("value_prior %h, want %h",
						m_axis_tdata[75:44], want.value_prior));
				if (m_axis_tdata[76] !== want.switch_level)
					note_failure($sformatf("switch_level %b, want %b",
						m_axis_tdata[76], want.switch_level));
				if (m_axis_tdata[79:77] !== 3'b000)
					note_failure($sformatf("pad bits %b", m_axis_tdata[79:77]));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int i;
		for (i = 0; i < WIN_DEPTH; i++)
			win_bytes[i] = 8'h00;
		parse_phase = PH_HEADER;
		hunting_slash = 1'b0;
		count_left = 4'd0;
		pair_values = 1'b0;
		control_sel = CTRL_NONE;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_page_headers();
		test_control_updates();
		test_output_backpressure();
		test_random_traffic(1600, 1'b1);
		test_steady_stream(1900);

		wait_for_results();
		repeat (20) @(posedge clk);
		if (expected_events.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_events.size()));
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
